### hw/rtl/assert_macros.svh
// Assertion macros for the checker file pva_checker.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### hw/rtl/pva_pkg.sv
// Shared types and codes for the priority vector allocator.
// No dependencies.
package pva_pkg;

   localparam int SLOTS_PER_LEVEL  = 16;
   localparam int REACHABLE_LEVELS = 16;

   typedef logic [1:0]  opcode_type;
   typedef logic [1:0]  status_type;
   typedef logic [7:0]  vector_type;
   typedef logic [3:0]  level_type;
   typedef logic [15:0] word_type;
   typedef logic [3:0]  slot_type;

   localparam opcode_type OP_RESERVE = 2'd0;
   localparam opcode_type OP_ALLOC   = 2'd1;
   localparam opcode_type OP_FREE    = 2'd2;

   localparam status_type STATUS_OK           = 2'd0;
   localparam status_type STATUS_ALREADY_USED = 2'd1;
   localparam status_type STATUS_NONE_FREE    = 2'd2;

endpackage

### hw/rtl/priority_vector_allocator.sv
// Priority vector allocator: used/free map of interrupt vectors, 16 per level.
// Depends on pva_pkg.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+-----------------------------------
//   req      | in        | req_valid / req_stall  | req_opcode, req_vector, req_level
//   rsp      | out       | rsp_valid / rsp_stall  | rsp_granted_vector, rsp_status
//
// Reserve and free update one level word. Allocate scans level words upward from the
// requested level, at most 16 of them: the map memory delivers one level word per cycle
// and the scan walks up one word each cycle while no held result blocks the output
// register. Synchronous active-high reset empties the map at once through per-level
// valid bits. One item is in work at a time; req_stall is high while it is. A finished
// result sits in the output register, so the next item is taken while rsp_stall holds it.
module priority_vector_allocator #(
   parameter int LEVELS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pva_pkg::opcode_type req_opcode,
   input  pva_pkg::vector_type req_vector,
   input  pva_pkg::level_type  req_level,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pva_pkg::vector_type rsp_granted_vector,
   output pva_pkg::status_type rsp_status
);
   import pva_pkg::*;

   // map address width, at least one bit
   localparam int AW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   // allocation never looks above what an 8-bit vector can name
   localparam int LIMIT = (LEVELS < REACHABLE_LEVELS) ? LEVELS : REACHABLE_LEVELS;

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   // control and item registers
   state_type  state_ff, state_in;
   opcode_type op_ff, op_in;
   vector_type vec_ff, vec_in;
   level_type  cur_ff, cur_in;      // level word now being looked at
   logic       rsp_valid_ff, rsp_valid_in;
   vector_type rsp_granted_ff, rsp_granted_in;
   status_type rsp_status_ff, rsp_status_in;

   // map storage: one 16-bit word per level, read data registered
   word_type          map_mem [LEVELS];
   logic [LEVELS-1:0] row_valid_ff;   // cleared by reset, an invalid row reads as free
   word_type          rdata_ff;
   logic              rvalid_ff;

   logic [AW-1:0] rd_idx;
   logic [AW-1:0] wr_idx;
   logic          wr_en;
   word_type      wr_data;

   word_type  word;
   word_type  vbit;
   word_type  lowest_free;
   slot_type  slot;
   logic      out_free;
   logic      in_map;
   logic      in_scan;
   logic      next_in_scan;

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted_vector = rsp_granted_ff;
   assign rsp_status         = rsp_status_ff;

   // the word is read at the address of the next cycle, so it lines up with cur_ff
   assign rd_idx = AW'(cur_in);
   assign wr_idx = AW'(cur_ff);

   assign word        = rvalid_ff ? rdata_ff : '0;
   assign vbit        = word_type'(1) << vec_ff[3:0];
   // isolate lowest zero bit: ~w & (w + 1)
   assign lowest_free = ~word & (word + word_type'(1));

   always_comb begin
      slot = '0;
      for (int i = 0; i < SLOTS_PER_LEVEL; i++) begin
         if (lowest_free[i]) begin
            slot = slot | slot_type'(i);
         end
      end
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign in_map       = (32'(cur_ff) < LEVELS);
   assign in_scan      = (32'(cur_ff) < LIMIT);
   assign next_in_scan = (32'(cur_ff) + 32'd1 < LIMIT);

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      vec_in         = vec_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      wr_data        = word;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = req_opcode;
               vec_in   = req_vector;
               cur_in   = (req_opcode == OP_ALLOC) ? req_level : req_vector[7:4];
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // results and map updates only when the output register can take them
            if (out_free) begin
               case (op_ff)
                  OP_RESERVE: begin
                     wr_en          = in_map;
                     wr_data        = word | vbit;
                     rsp_granted_in = '0;
                     rsp_status_in  = (in_map && ((word & vbit) != '0)) ?
                                      STATUS_ALREADY_USED : STATUS_OK;
                     rsp_valid_in   = 1'b1;
                     state_in       = S_IDLE;
                  end
                  OP_FREE: begin
                     wr_en          = in_map;
                     wr_data        = word & ~vbit;
                     rsp_granted_in = '0;
                     rsp_status_in  = STATUS_OK;
                     rsp_valid_in   = 1'b1;
                     state_in       = S_IDLE;
                  end
                  OP_ALLOC: begin
                     if (in_scan && (word != '1)) begin
                        wr_en          = 1'b1;
                        wr_data        = word | lowest_free;
                        rsp_granted_in = {cur_ff, slot};
                        rsp_status_in  = STATUS_OK;
                        rsp_valid_in   = 1'b1;
                        state_in       = S_IDLE;
                     end else if (in_scan && next_in_scan) begin
                        // level full, move up one level
                        cur_in = cur_ff + level_type'(1);
                     end else begin
                        rsp_granted_in = '0;
                        rsp_status_in  = STATUS_NONE_FREE;
                        rsp_valid_in   = 1'b1;
                        state_in       = S_IDLE;
                     end
                  end
                  default: begin
                     // unused opcode: no map change
                     rsp_granted_in = '0;
                     rsp_status_in  = STATUS_OK;
                     rsp_valid_in   = 1'b1;
                     state_in       = S_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      vec_ff         <= vec_in;
      cur_ff         <= cur_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // map memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_idx] <= wr_data;
      end
      rdata_ff  <= map_mem[rd_idx];
      rvalid_ff <= row_valid_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_idx] <= 1'b1;
      end
   end

endmodule

### hw/rtl/pva_checker.sv
// Port-level checks for the priority vector allocator, bound to the top level.
// Depends on pva_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pva_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input pva_pkg::vector_type rsp_granted_vector,
   input pva_pkg::status_type rsp_status
);
   import pva_pkg::*;

   logic       req_take;
   logic       rsp_held;
   logic       granted;
   logic       status_ok;
   logic [9:0] rsp_word;

   assign req_take  = req_valid && !req_stall;
   assign rsp_held  = rsp_valid && rsp_stall;
   assign granted   = rsp_valid && (rsp_granted_vector != '0);
   assign status_ok = (rsp_status == STATUS_OK);
   assign rsp_word  = {rsp_granted_vector, rsp_status};

   // the block is busy in the cycle after it accepts an item
   `ASSERT_CLK(a_busy_after_accept, req_take |=> req_stall, "no busy after accept")

   // a nonzero grant only comes with an ok status
   `ASSERT_CLK(a_grant_ok, granted |-> status_ok, "grant with bad status")

   // a held result does not change
   `ASSERT_CLK(a_rsp_hold, rsp_held |=> (rsp_valid && $stable(rsp_word)), "held result changed")

   // reset empties the output register
   `ASSERT_CLK_ALWAYS(a_reset_rsp, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind priority_vector_allocator pva_checker u_pva_checker (.*);
